// ===== design/tpq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and defaults for the two-tier priority slot queue.
package tpq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  typedef enum logic [2:0] {
    FN_INSERT  = 3'd0,
    FN_POP     = 3'd1,
    FN_REMOVE  = 3'd2,
    FN_PROMOTE = 3'd3,
    FN_FIND    = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_DEL,
    S_RESTART,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic        urg;
    logic [15:0] pri;
    logic [9:0]  id;
  } entry_t;

  typedef struct packed {
    logic [2:0]  func;
    logic [9:0]  slot_id;
    logic [15:0] eta_time;
    logic [15:0] takeoff_time;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  out_id;
    logic [15:0] out_priority;
    logic        out_urgent;
    logic [4:0]  occupancy;
  } res_t;

endpackage

// ===== design/tpq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
interface tpq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [9:0]  slot_id;
  logic [15:0] eta_time;
  logic [15:0] takeoff_time;

  modport source (output valid, func, slot_id, eta_time, takeoff_time, input ready);
  modport sink (input valid, func, slot_id, eta_time, takeoff_time, output ready);
endinterface

interface tpq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  out_id;
  logic [15:0] out_priority;
  logic        out_urgent;
  logic [4:0]  occupancy;

  modport source (output valid, status, out_id, out_priority, out_urgent, occupancy,
                  input ready);
  modport sink (input valid, status, out_id, out_priority, out_urgent, occupancy,
                output ready);
endinterface

// ===== design/tpq_mem.sv =====
`timescale 1ns / 1ps
// Entry store: one write port, one read port with registered read data.
module tpq_mem import tpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/tpq_seq.sv =====
`timescale 1ns / 1ps
// Sequencer: streams the queue through the store, inserting or closing gaps.
module tpq_seq import tpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  in_item_t      in_item,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output entry_t        mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  entry_t        mem_rdata
);

  seq_state_t state_r, state_nxt;
  func_t      op_r, op_nxt;
  logic [9:0] id_r, id_nxt;
  entry_t     ent_r, ent_nxt;
  entry_t     carry_r, carry_nxt;
  logic       placed_r, placed_nxt;
  logic       found_r, found_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  status_t    status_r, status_nxt;

  logic [CW-1:0] idx_plus, idx_minus;
  logic [15:0]   pri_in;
  logic          is_full, is_empty;
  logic          ins_end, ins_fits, ins_take;
  logic          del_last, del_match, del_hit;
  entry_t        hit_ent;

  assign idx_plus  = idx_r + CW'(1);
  assign idx_minus = idx_r - CW'(1);
  assign pri_in    = (in_item.eta_time > in_item.takeoff_time) ?
                     in_item.eta_time : in_item.takeoff_time;
  assign is_full   = (count_r == CW'(QUEUE_DEPTH));
  assign is_empty  = (count_r == '0);

  // Insert pass: place before first entry of the same tier not below it,
  // skipping past the urgent prefix for a non-urgent entry.
  assign ins_end  = (idx_r == count_r);
  assign ins_fits = ent_r.urg ? (!mem_rdata.urg || (mem_rdata.pri >= ent_r.pri))
                              : (!mem_rdata.urg && (mem_rdata.pri >= ent_r.pri));
  assign ins_take = !placed_r && (ins_end || ins_fits);

  assign del_last  = (idx_r == idx_minus + CW'(1)) && (idx_r == count_r - CW'(1));
  assign del_match = (op_r == FN_POP) ? (idx_r == '0) : (mem_rdata.id == id_r);
  assign del_hit   = !found_r && del_match;
  assign hit_ent   = del_hit ? mem_rdata : ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    ent_r    <= ent_nxt;
    carry_r  <= carry_nxt;
    placed_r <= placed_nxt;
    found_r  <= found_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    id_nxt     = id_r;
    ent_nxt    = ent_r;
    carry_nxt  = carry_r;
    placed_nxt = placed_r;
    found_nxt  = found_r;
    idx_nxt    = idx_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_wdata  = ent_r;
    mem_raddr  = idx_plus[AW-1:0];
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        mem_raddr  = '0;
        if (in_valid) begin
          op_nxt     = func_t'(in_item.func);
          id_nxt     = in_item.slot_id;
          ent_nxt    = '{urg: 1'b0, pri: pri_in, id: in_item.slot_id};
          placed_nxt = 1'b0;
          found_nxt  = 1'b0;
          idx_nxt    = '0;
          status_nxt = ST_OK;
          case (func_t'(in_item.func))
            FN_INSERT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_INS;
              end
            end
            FN_POP: begin
              if (is_empty) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_DEL;
              end
            end
            FN_REMOVE, FN_PROMOTE, FN_FIND: begin
              if (is_empty) begin
                status_nxt = ST_NOTFOUND;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_DEL;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end

      S_INS: begin
        // write slot i while slot i+1 is being read
        mem_we     = ins_take || placed_r;
        mem_wdata  = placed_r ? carry_r : ent_r;
        carry_nxt  = mem_rdata;
        placed_nxt = placed_r || ins_take;
        if (ins_end) begin
          count_nxt = count_r + CW'(1);
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_plus;
        end
      end

      S_DEL: begin
        // entries past the hit move down one slot; find writes nothing
        mem_we    = found_r && (op_r != FN_FIND);
        mem_waddr = idx_minus[AW-1:0];
        mem_wdata = mem_rdata;
        if (del_hit) begin
          ent_nxt   = mem_rdata;
          found_nxt = 1'b1;
        end
        if (del_last) begin
          if (!(found_r || del_hit)) begin
            status_nxt = ST_NOTFOUND;
            state_nxt  = S_DONE;
          end else if (op_r == FN_FIND) begin
            state_nxt = S_DONE;
          end else begin
            count_nxt = count_r - CW'(1);
            if (op_r == FN_PROMOTE) begin
              ent_nxt   = '{urg: 1'b1, pri: hit_ent.pri, id: hit_ent.id};
              state_nxt = S_RESTART;
            end else begin
              state_nxt = S_DONE;
            end
          end
        end else begin
          idx_nxt = idx_plus;
        end
      end

      S_RESTART: begin
        // last gap-closing write has landed; start the reinsert at the head
        mem_raddr  = '0;
        idx_nxt    = '0;
        placed_nxt = 1'b0;
        state_nxt  = S_INS;
      end

      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  logic show_ent;
  assign show_ent = (status_r == ST_OK) && ((op_r == FN_POP) || (op_r == FN_FIND));

  always_comb begin
    res.status       = status_r;
    res.out_id       = show_ent ? ent_r.id : '0;
    res.out_priority = show_ent ? ent_r.pri : '0;
    res.out_urgent   = show_ent ? ent_r.urg : 1'b0;
    res.occupancy    = 5'(count_r);
  end

endmodule

// ===== design/tpq_out.sv =====
`timescale 1ns / 1ps
// Result register: holds one finished result until the sink takes it.
module tpq_out import tpq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic res_valid,
  output logic res_ready,
  input  res_t res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic out_valid_r;
  res_t out_res_r;

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ===== design/two_tier_priority_slot_queue_core.sv =====
`timescale 1ns / 1ps
// Top level of the two-tier priority slot queue.
//
//   channel   dir  handshake          payload
//   in_chan   in   valid/ready        func, slot_id, eta_time, takeoff_time
//   out_chan  out  valid/ready        status, out_id, out_priority, out_urgent, occupancy
//
// One transaction at a time; each pass streams the queue through the store,
// one entry per cycle. Promote runs a remove pass then a reinsert pass;
// full/empty rejects and unknown codes skip the passes. Reset (synchronous,
// rst_n low) empties the queue; the store is not cleared. A stalled result
// sits in the output register while the next transaction is taken in.
module two_tier_priority_slot_queue_core import tpq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input logic       clk,
  input logic       rst_n,
  tpq_in_if.sink    in_chan,
  tpq_out_if.source out_chan
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  in_item_t      in_item;
  res_t          res, out_res;
  logic          res_valid, res_ready;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata, mem_rdata;

  assign in_item = '{func: in_chan.func, slot_id: in_chan.slot_id,
                     eta_time: in_chan.eta_time, takeoff_time: in_chan.takeoff_time};

  tpq_seq #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tpq_mem #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tpq_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_res   (out_res)
  );

  assign out_chan.status       = out_res.status;
  assign out_chan.out_id       = out_res.out_id;
  assign out_chan.out_priority = out_res.out_priority;
  assign out_chan.out_urgent   = out_res.out_urgent;
  assign out_chan.occupancy    = out_res.occupancy;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("request taken while a transaction is in flight");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_FULL)) |-> (out_chan.occupancy == 5'(QUEUE_DEPTH)))
    else $error("full reported with queue not full");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status == ST_EMPTY)) |-> (out_chan.occupancy == 5'd0))
    else $error("empty reported with entries held");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != ST_OK)) |->
      ((out_chan.out_id == '0) && (out_chan.out_priority == '0) && !out_chan.out_urgent))
    else $error("failed transaction carries entry data");

endmodule
